>>> rtl/core/sfbs_pkg.sv
// ----------------------------------------------------------------------------
// sfbs_pkg: shared types and functions of the four-byte block scrambler
// Holds the job format passed from the front to the back, the register
// indexes and the block transforms.
// ----------------------------------------------------------------------------
package sfbs_pkg;

   localparam int unsigned DEFAULT_QUEUE_DEPTH = 2;
   localparam int unsigned CSR_INDEX_W         = 1;
   localparam int unsigned CSR_DATA_W          = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_MODE = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] REG_SEED = 1'b1;

   localparam logic MODE_ENCRYPT = 1'b0;
   localparam logic MODE_DECRYPT = 1'b1;

   // Sequence positions inside one job: header first, then four block bytes.
   localparam logic [2:0] POS_HEADER     = 3'd0;
   localparam logic [2:0] POS_FIRST_BYTE = 3'd1;
   localparam logic [2:0] POS_LAST_BYTE  = 3'd4;

   typedef logic [3:0][7:0] block_type;

   // One unit of work for the back end: an optional header byte and an
   // optional block, both caused by a single input transfer.
   typedef struct packed {
      logic      has_header;
      logic      has_block;
      logic      last;
      logic      mode;
      logic [7:0] seed;
      block_type block;
   } job_type;

   function automatic block_type scramble(block_type src, logic [7:0] s);
      block_type a;
      block_type x;
      for (int k = 0; k < 4; k++) begin
         a[k] = src[k] + s + 8'(k);
      end
      for (int k = 0; k < 4; k++) begin
         x[k] = a[3-k] ^ (s + 8'(k));
      end
      x[0] = x[0] ^ x[2];
      x[1] = x[1] ^ x[3];
      return x;
   endfunction

   function automatic block_type unscramble(block_type src, logic [7:0] s);
      block_type d;
      block_type x;
      block_type y;
      d[0] = src[0] ^ src[2];
      d[1] = src[1] ^ src[3];
      d[2] = src[2];
      d[3] = src[3];
      for (int k = 0; k < 4; k++) begin
         x[k] = d[k] ^ (s + 8'(k));
      end
      for (int k = 0; k < 4; k++) begin
         y[k] = x[3-k] - (s + 8'(k));
      end
      return y;
   endfunction

endpackage

>>> rtl/core/seeded_four_byte_block_scrambler_unit.sv
// ----------------------------------------------------------------------------
// seeded_four_byte_block_scrambler_unit: seeded four-byte block scrambler
// Path: the first result byte of a transfer passes the job queue, the back's
// work registers and the output register. Unless stalled, a block's four
// bytes follow on consecutive cycles. Throughput, unless stalled: one input
// byte in, one result byte out per cycle; each encrypt message adds a header.
// Reset: synchronous and active high; clears configuration, message state,
// the job queue and the output register. No clearing pass is needed.
// ----------------------------------------------------------------------------
module seeded_four_byte_block_scrambler_unit
   import sfbs_pkg::*;
#(
   parameter int unsigned QUEUE_DEPTH = DEFAULT_QUEUE_DEPTH
)
(
   input  logic                   clock,
   input  logic                   reset,
   // Configuration write port.
   input  logic                   csr_write,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_wdata,
   // Input byte channel.
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic [7:0]             req_data_byte,
   input  logic                   req_last,
   // Result byte channel.
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [7:0]             rsp_out_byte,
   output logic                   rsp_run_end,
   output logic                   rsp_message_end
);

   // Configuration registers. Mode is sampled with every input transfer, so
   // a change takes effect on the next block; the seed is latched by the
   // front at the start of an encrypt message.
   logic       mode_ff, mode_in;
   logic [7:0] seed_ff, seed_in;

   always_comb begin
      mode_in = mode_ff;
      seed_in = seed_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_MODE: mode_in = csr_wdata[0];
            REG_SEED: seed_in = csr_wdata[7:0];
            default:  ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ENCRYPT;
         seed_ff <= 8'd0;
      end else begin
         mode_ff <= mode_in;
         seed_ff <= seed_in;
      end
   end

   // The front accepts one byte per transfer whenever the queue has room;
   // it never waits on the result side directly.
   logic    req_accept;
   logic    q_push;
   job_type q_push_job;
   logic    q_pop;
   logic    q_head_valid;
   job_type q_head_job;
   logic    q_full;

   assign req_stall  = q_full;
   assign req_accept = req_valid && !q_full;

   sfbs_front u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (req_accept),
      .data_byte (req_data_byte),
      .last      (req_last),
      .cfg_mode  (mode_ff),
      .cfg_seed  (seed_ff),
      .push      (q_push),
      .job       (q_push_job)
   );

   // Each queued job is the complete output of one input transfer: a header
   // byte, a block of four bytes, or both.
   sfbs_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (q_push),
      .push_job   (q_push_job),
      .pop        (q_pop),
      .head_valid (q_head_valid),
      .head_job   (q_head_job),
      .full       (q_full)
   );

   // The back transforms a block when it takes the job and then drains the
   // bytes through a registered output, taking the next job on the cycle the
   // last byte leaves so the output runs without bubbles.
   sfbs_back u_back (
      .clock           (clock),
      .reset           (reset),
      .head_valid      (q_head_valid),
      .head_job        (q_head_job),
      .pop             (q_pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_end     (rsp_run_end),
      .rsp_message_end (rsp_message_end)
   );

endmodule

>>> rtl/core/sfbs_front.sv
// ----------------------------------------------------------------------------
// sfbs_front: byte intake and block assembly
// Tracks message start, latches the seed, gathers bytes into blocks of four
// and hands a job to the queue for every transfer that causes output.
// ----------------------------------------------------------------------------
module sfbs_front
   import sfbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       accept,
   input  logic [7:0] data_byte,
   input  logic       last,
   input  logic       cfg_mode,
   input  logic [7:0] cfg_seed,
   output logic       push,
   output job_type    job
);

   logic       in_msg_ff, in_msg_in;
   logic [1:0] fill_ff, fill_in;
   logic [7:0] seed_ff, seed_in;
   logic [7:0] buf_ff [3];
   logic       buf_we;
   logic [1:0] buf_idx;

   always_comb begin
      in_msg_in     = in_msg_ff;
      fill_in       = fill_ff;
      seed_in       = seed_ff;
      buf_we        = 1'b0;
      buf_idx       = fill_ff;
      push          = 1'b0;
      job.has_header = 1'b0;
      job.has_block  = 1'b0;
      job.last       = last;
      job.mode       = cfg_mode;
      job.seed       = seed_ff;
      job.block      = '0;
      if (accept) begin
         if (!in_msg_ff) begin
            in_msg_in = 1'b1;
            if (cfg_mode == MODE_DECRYPT) begin
               // The first byte is the seed; only a lone seed byte emits a block.
               seed_in       = data_byte;
               job.seed      = data_byte;
               job.has_block = last;
               push          = last;
               fill_in       = 2'd0;
            end else begin
               seed_in        = cfg_seed;
               job.seed       = cfg_seed;
               job.has_header = 1'b1;
               job.has_block  = last;
               job.block[0]   = data_byte;
               push           = 1'b1;
               buf_we         = 1'b1;
               buf_idx        = 2'd0;
               fill_in        = 2'd1;
            end
         end else if (fill_ff == 2'd3 || last) begin
            for (int k = 0; k < 3; k++) begin
               if (2'(k) < fill_ff) begin
                  job.block[k] = buf_ff[k];
               end
            end
            job.block[fill_ff] = data_byte;
            job.has_block      = 1'b1;
            push               = 1'b1;
            fill_in            = 2'd0;
         end else begin
            buf_we  = 1'b1;
            fill_in = fill_ff + 2'd1;
         end
         if (last) begin
            in_msg_in = 1'b0;
            fill_in   = 2'd0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         fill_ff   <= 2'd0;
         seed_ff   <= 8'd0;
      end else begin
         in_msg_ff <= in_msg_in;
         fill_ff   <= fill_in;
         seed_ff   <= seed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (buf_we) begin
         buf_ff[buf_idx] <= data_byte;
      end
   end

endmodule

>>> rtl/core/sfbs_queue.sv
// ----------------------------------------------------------------------------
// sfbs_queue: job queue between front and back
// A small first-in first-out store of jobs so each side can stall alone.
// ----------------------------------------------------------------------------
module sfbs_queue
   import sfbs_pkg::*;
#(
   parameter int unsigned DEPTH = DEFAULT_QUEUE_DEPTH
)
(
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job,
   output logic    full
);

   localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   job_type       mem_ff [DEPTH];
   logic [PW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign head_valid = (count_ff != '0);
   assign full       = (count_ff == CW'(DEPTH));
   assign head_job   = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("queue count exceeds depth");
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      full && push |-> pop)
      else $error("job pushed into a full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("job popped from an empty queue");
`endif

endmodule

>>> rtl/core/sfbs_back.sv
// ----------------------------------------------------------------------------
// sfbs_back: block transform and byte emission
// Takes a job, applies the scramble or its inverse, and sends the header
// and block bytes one per transfer through an output register.
// ----------------------------------------------------------------------------
module sfbs_back
   import sfbs_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       head_valid,
   input  job_type    head_job,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_end,
   output logic       rsp_message_end
);

   logic       work_valid_ff, work_valid_in;
   logic [2:0] pos_ff, pos_in;
   logic [2:0] end_ff, end_in;
   logic [7:0] hdr_ff, hdr_in;
   logic       last_ff, last_in;
   block_type  res_ff, res_in;

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] rsp_byte_ff, rsp_byte_in;
   logic       rsp_run_end_ff, rsp_run_end_in;
   logic       rsp_msg_end_ff, rsp_msg_end_in;

   logic       out_free;
   logic       emit;
   logic       finish;
   logic [1:0] res_idx;

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign emit     = work_valid_ff && out_free;
   assign finish   = emit && (pos_ff == end_ff);
   assign pop      = head_valid && (!work_valid_ff || finish);
   assign res_idx  = 2'(pos_ff - POS_FIRST_BYTE);

   always_comb begin
      work_valid_in = work_valid_ff;
      pos_in        = pos_ff;
      end_in        = end_ff;
      hdr_in        = hdr_ff;
      last_in       = last_ff;
      res_in        = res_ff;
      if (pop) begin
         work_valid_in = 1'b1;
         pos_in  = head_job.has_header ? POS_HEADER : POS_FIRST_BYTE;
         end_in  = head_job.has_block ? POS_LAST_BYTE : POS_HEADER;
         hdr_in  = head_job.seed;
         last_in = head_job.last;
         res_in  = (head_job.mode == MODE_DECRYPT) ?
                   unscramble(head_job.block, head_job.seed) :
                   scramble(head_job.block, head_job.seed);
      end else if (finish) begin
         work_valid_in = 1'b0;
      end else if (emit) begin
         pos_in = pos_ff + 3'd1;
      end
   end

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      rsp_byte_in    = rsp_byte_ff;
      rsp_run_end_in = rsp_run_end_ff;
      rsp_msg_end_in = rsp_msg_end_ff;
      if (emit) begin
         rsp_valid_in   = 1'b1;
         rsp_byte_in    = (pos_ff == POS_HEADER) ? hdr_ff : res_ff[res_idx];
         rsp_run_end_in = (pos_ff == end_ff);
         rsp_msg_end_in = last_ff && (pos_ff == POS_LAST_BYTE);
      end else if (out_free) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         work_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         work_valid_ff <= work_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff         <= pos_in;
      end_ff         <= end_in;
      hdr_ff         <= hdr_in;
      last_ff        <= last_in;
      res_ff         <= res_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_run_end_ff <= rsp_run_end_in;
      rsp_msg_end_ff <= rsp_msg_end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_run_end     = rsp_run_end_ff;
   assign rsp_message_end = rsp_msg_end_ff;

`ifndef SYNTHESIS
   a_pos_in_range: assert property (@(posedge clock) disable iff (reset)
      work_valid_ff |-> pos_ff <= end_ff)
      else $error("emit position beyond end of job");
   a_msg_end_closes_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_msg_end_ff |-> rsp_run_end_ff)
      else $error("message end without run end");
   a_emit_loads_output: assert property (@(posedge clock) disable iff (reset)
      emit |=> rsp_valid_ff)
      else $error("emitted byte did not reach the output register");
`endif

endmodule

>>> tb/sv/seeded_four_byte_block_scrambler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// seeded_four_byte_block_scrambler_unit_tb: self-checking bench for the scrambler
// Streams messages through the byte channel in both encrypt and decrypt
// modes. A behavioral predictor works out the expected result bytes for every
// accepted input transfer, and every result transfer is checked against them.
// ----------------------------------------------------------------------------
module seeded_four_byte_block_scrambler_unit_tb
   import sfbs_pkg::*;
;

   localparam int CYCLE_LIMIT    = 200000;
   localparam int SETTLE_CYCLES  = 6;
   localparam int RANDOM_PHASES  = 8;
   localparam int BYTES_PER_PHASE = 62;

   // One byte offered on the input channel. A set drain_first makes the
   // sender hold this byte back until every outstanding result has arrived.
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last;
      logic       drain_first;
   } byte_xfer_type;

   // One byte expected on the result channel.
   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_end;
      logic       message_end;
   } scrambled_byte_type;

   typedef logic [3:0][7:0] quad_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic [7:0]             req_data_byte = '0;
   logic                   req_last = 1'b0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [7:0]             rsp_out_byte;
   logic                   rsp_run_end;
   logic                   rsp_message_end;

   seeded_four_byte_block_scrambler_unit u_dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_data_byte   (req_data_byte),
      .req_last        (req_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_run_end     (rsp_run_end),
      .rsp_message_end (rsp_message_end)
   );

   // Bytes waiting to be offered and result bytes waiting to be seen.
   byte_xfer_type      pending_bytes[$];
   scrambled_byte_type expected_bytes[$];

   // Mirror of the configuration registers, updated as they are written.
   logic       cfg_mode = MODE_ENCRYPT;
   logic [7:0] cfg_seed = 8'h00;

   // Predictor copy of the message state.
   logic [7:0] held_bytes[3];
   int         held_count = 0;
   logic       msg_open = 1'b0;
   logic [7:0] msg_seed = 8'h00;

   // Handshake bookkeeping shared between the processes. results_pending and
   // bytes_accepted only change with nonblocking updates so that readers at
   // the same edge always see the values of the previous cycle.
   logic results_pending = 1'b0;
   int   bytes_accepted  = 0;
   int   bytes_queued    = 0;
   int   sender_odds     = 0;
   int   receiver_odds   = 0;
   int   gap_left        = 0;
   int   stall_left      = 0;
   int   cycle_count     = 0;

   // Run statistics.
   int errors          = 0;
   int results_checked = 0;
   int headers_seen    = 0;
   int encrypt_blocks  = 0;
   int decrypt_blocks  = 0;
   int seed_only_msgs  = 0;

   logic               send_now;
   byte_xfer_type      send_item;
   logic               stall_next;
   scrambled_byte_type want;

   // Encrypt one block: add the offset of the source position, reverse the
   // byte order, XOR with the offset of the destination position, then fold
   // the upper half onto the lower half.
   function automatic quad_type scramble_quad(quad_type plain, logic [7:0] key);
      quad_type   t;
      logic [7:0] add_off;
      logic [7:0] xor_off;
      for (int j = 0; j < 4; j++) begin
         add_off = key + 8'(3 - j);
         xor_off = key + 8'(j);
         t[j]    = (plain[3-j] + add_off) ^ xor_off;
      end
      t[0] = t[0] ^ t[2];
      t[1] = t[1] ^ t[3];
      return t;
   endfunction

   // Undo scramble_quad step by step in reverse order.
   function automatic quad_type unscramble_quad(quad_type coded, logic [7:0] key);
      quad_type v;
      quad_type plain;
      v    = coded;
      v[0] = coded[0] ^ coded[2];
      v[1] = coded[1] ^ coded[3];
      for (int j = 0; j < 4; j++) begin
         v[j] = v[j] ^ (key + 8'(j));
      end
      for (int j = 0; j < 4; j++) begin
         plain[j] = v[3-j] - (key + 8'(j));
      end
      return plain;
   endfunction

   // Advance the predicted message state by one accepted input transfer and
   // append the result bytes it causes to expected_bytes.
   task automatic predict_results(input logic [7:0] b, input logic lst);
      quad_type           blk;
      quad_type           coded;
      logic               emit;
      scrambled_byte_type batch[$];
      scrambled_byte_type entry;
      blk  = '0;
      emit = 1'b0;
      if (!msg_open) begin
         msg_open   = 1'b1;
         held_count = 0;
         if (cfg_mode == MODE_DECRYPT) begin
            // The first byte of a decrypt message is its seed, not data.
            msg_seed = b;
            if (lst) begin
               emit = 1'b1;
               seed_only_msgs++;
            end
         end else begin
            // Encrypt latches the seed register and sends it as a header.
            msg_seed = cfg_seed;
            entry = '{out_byte: cfg_seed, run_end: 1'b0, message_end: 1'b0};
            batch.push_back(entry);
            headers_seen++;
            held_bytes[0] = b;
            held_count    = 1;
            if (lst) begin
               blk[0] = b;
               emit   = 1'b1;
            end
         end
      end else if (held_count == 3 || lst) begin
         // A full block, or a short final block padded with zeros.
         for (int k = 0; k < held_count; k++) begin
            blk[k] = held_bytes[k];
         end
         blk[held_count] = b;
         emit       = 1'b1;
         held_count = 0;
      end else begin
         held_bytes[held_count] = b;
         held_count++;
      end

      if (emit) begin
         // The mode register is read on every transfer, so a mode change
         // inside a message switches the transform of the later blocks.
         if (cfg_mode == MODE_DECRYPT) begin
            coded = unscramble_quad(blk, msg_seed);
            decrypt_blocks++;
         end else begin
            coded = scramble_quad(blk, msg_seed);
            encrypt_blocks++;
         end
         for (int k = 0; k < 4; k++) begin
            entry = '{out_byte: coded[k], run_end: 1'b0, message_end: lst && k == 3};
            batch.push_back(entry);
         end
         held_count = 0;
      end

      if (lst) begin
         msg_open   = 1'b0;
         held_count = 0;
      end

      if (batch.size() != 0) begin
         batch[batch.size()-1].run_end = 1'b1;
      end
      foreach (batch[i]) begin
         expected_bytes.push_back(batch[i]);
      end
   endtask

   initial begin
      forever #5 clock = ~clock;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles, %0d result bytes still expected",
                  $time, cycle_count, expected_bytes.size());
         $display("seeded_four_byte_block_scrambler_unit_tb: FAIL");
         $finish;
      end
   end

   // Sender. A byte stays on the channel, unchanged, until the transfer
   // completes; between transfers it may idle at random.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         gap_left  = 0;
      end else begin
         if (req_valid && !req_stall) begin
            bytes_accepted <= bytes_accepted + 1;
         end
         if (!(req_valid && req_stall)) begin
            send_now = 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else if (pending_bytes.size() != 0) begin
               if (pending_bytes[0].drain_first && (req_valid || results_pending)) begin
                  // Hold off until the block has delivered everything so far.
                  send_now = 1'b0;
               end else if (sender_odds != 0 && $urandom_range(1, sender_odds) == 1) begin
                  gap_left = $urandom_range(0, 7);
               end else begin
                  send_item = pending_bytes.pop_front();
                  send_now  = 1'b1;
               end
            end
            req_valid <= send_now;
            if (send_now) begin
               req_data_byte <= send_item.data_byte;
               req_last      <= send_item.last;
            end
         end
      end
   end

   // Receiver and checker. Prediction happens in this same process ahead of
   // the comparison, so a result can never race its own expectation.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall       <= 1'b0;
         results_pending <= 1'b0;
         stall_left      = 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_results(req_data_byte, req_last);
         end

         if (rsp_valid && !rsp_stall) begin
            if (expected_bytes.size() == 0) begin
               errors++;
               $display("%0t: unexpected result, byte %02h run_end %0b message_end %0b",
                        $time, rsp_out_byte, rsp_run_end, rsp_message_end);
            end else begin
               want = expected_bytes.pop_front();
               results_checked++;
               if (rsp_out_byte !== want.out_byte) begin
                  errors++;
                  $display("%0t: out_byte mismatch, expected %02h, actual %02h",
                           $time, want.out_byte, rsp_out_byte);
               end
               if (rsp_run_end !== want.run_end) begin
                  errors++;
                  $display("%0t: run_end mismatch, expected %0b, actual %0b",
                           $time, want.run_end, rsp_run_end);
               end
               if (rsp_message_end !== want.message_end) begin
                  errors++;
                  $display("%0t: message_end mismatch, expected %0b, actual %0b",
                           $time, want.message_end, rsp_message_end);
               end
            end
         end
         results_pending <= (expected_bytes.size() != 0);

         if (stall_left > 0) begin
            stall_left--;
            stall_next = 1'b1;
         end else if (receiver_odds != 0 && $urandom_range(1, receiver_odds) == 1) begin
            stall_left = $urandom_range(0, 7);
            stall_next = 1'b1;
         end else begin
            stall_next = 1'b0;
         end
         rsp_stall <= stall_next;
      end
   end

   task automatic queue_byte(input logic [7:0] b, input logic lst, input logic drain);
      byte_xfer_type item;
      item = '{data_byte: b, last: lst, drain_first: drain};
      pending_bytes.push_back(item);
      bytes_queued++;
   endtask

   // Random byte leaning toward the extremes now and then.
   function automatic logic [7:0] pick_byte();
      case ($urandom_range(0, 9))
         0: begin
            return 8'h00;
         end
         1: begin
            return 8'hFF;
         end
         default: begin
            return 8'($urandom_range(0, 255));
         end
      endcase
   endfunction

   task automatic queue_message(input int len, input logic close, input logic drain);
      for (int i = 0; i < len; i++) begin
         queue_byte(pick_byte(), close && i == len - 1, drain && i == 0);
      end
   endtask

   // Wait until every queued byte has been transferred and every expected
   // result has come back, then let the block settle.
   task automatic wait_until_drained();
      do begin
         @(posedge clock);
      end while (bytes_accepted != bytes_queued || results_pending);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Both registers are written on back-to-back edges while the block is idle.
   task automatic apply_settings(input logic m, input logic [7:0] s);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= REG_MODE;
      csr_wdata <= CSR_DATA_W'(m);
      @(posedge clock);
      csr_index <= REG_SEED;
      csr_wdata <= s;
      @(posedge clock);
      csr_write <= 1'b0;
      cfg_mode = m;
      cfg_seed = s;
   endtask

   initial begin
      int   phase_bytes;
      int   len;
      logic close;
      logic m;
      logic [7:0] s;

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed encrypt messages at the top seed value: a one-byte message,
      // an exact block of extreme bytes, and a block plus a short remainder.
      apply_settings(MODE_ENCRYPT, 8'hFF);
      @(negedge clock);
      sender_odds   = 3;
      receiver_odds = 3;
      queue_byte(8'hFF, 1'b1, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_byte(8'h80, 1'b0, 1'b0);
      queue_byte(8'h7F, 1'b1, 1'b0);
      for (int i = 1; i <= 5; i++) begin
         queue_byte(8'(i), i == 5, 1'b0);
      end
      wait_until_drained();

      // Directed decrypt messages: a message holding only its seed byte,
      // a full block after the seed, and one left open across a mode change.
      apply_settings(MODE_DECRYPT, 8'h00);
      @(negedge clock);
      queue_byte(8'hFF, 1'b1, 1'b0);
      queue_byte(8'h00, 1'b0, 1'b1);
      queue_byte(8'h5A, 1'b0, 1'b0);
      queue_byte(8'hA5, 1'b0, 1'b0);
      queue_byte(8'hFF, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b1, 1'b0);
      queue_byte(8'h80, 1'b0, 1'b0);
      queue_byte(8'h12, 1'b0, 1'b0);
      queue_byte(8'hED, 1'b0, 1'b0);
      wait_until_drained();

      // The open decrypt message finishes in encrypt mode and keeps its seed.
      apply_settings(MODE_ENCRYPT, 8'h3C);
      @(negedge clock);
      queue_byte(8'h34, 1'b0, 1'b0);
      queue_byte(8'hCB, 1'b0, 1'b0);
      queue_byte(8'h00, 1'b1, 1'b0);
      wait_until_drained();

      // Random phases, each under its own settings. The first two pin the
      // seed extremes; messages are mostly short so blocks end at every fill
      // level, and a phase may stop inside a message so that the next
      // settings apply partway through it. The closing phases run with
      // neither side idling.
      for (int p = 0; p < RANDOM_PHASES; p++) begin
         m = (p == 0) ? MODE_ENCRYPT : (p == 1) ? MODE_DECRYPT : 1'($urandom_range(0, 1));
         s = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : 8'($urandom_range(0, 255));
         apply_settings(m, s);
         @(negedge clock);
         if (p >= RANDOM_PHASES - 2) begin
            sender_odds   = 0;
            receiver_odds = 0;
         end else begin
            sender_odds   = 3 * $urandom_range(0, 2);
            receiver_odds = 3 * $urandom_range(0, 2);
         end
         phase_bytes = 0;
         while (phase_bytes < BYTES_PER_PHASE) begin
            len = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 24) : $urandom_range(1, 9);
            close = !(phase_bytes + len >= BYTES_PER_PHASE && p < RANDOM_PHASES - 1 &&
                      $urandom_range(0, 2) == 0);
            queue_message(len, close, $urandom_range(0, 7) == 0);
            phase_bytes += len;
         end
         wait_until_drained();
      end

      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_bytes.size() != 0) begin
         errors++;
         $display("%0t: %0d expected result bytes never arrived", $time, expected_bytes.size());
      end

      $display("Covered %0d input transfers and %0d checked result bytes, with %0d headers,",
               bytes_accepted, results_checked, headers_seen);
      $display("%0d encrypted and %0d decrypted blocks, %0d seed-only decrypt messages.",
               encrypt_blocks, decrypt_blocks, seed_only_msgs);
      if (errors == 0) begin
         $display("seeded_four_byte_block_scrambler_unit_tb: PASS");
      end else begin
         $display("seeded_four_byte_block_scrambler_unit_tb: FAIL");
      end
      $finish;
   end

endmodule
